// ===== hdl/c3af_pkg.sv =====
// ----------------------------------------------------------------------------
// c3af_pkg: shared types and constants of the 3x3 absolute filter
// Field widths, configuration register indexes and the records that pass
// between the window, multiply and sum stages.
// ----------------------------------------------------------------------------
package c3af_pkg;

  localparam int PixW    = 8;
  localparam int CoordW  = 10;
  localparam int SizeW   = 11;
  localparam int MaskW   = 24;
  localparam int CoefW   = 8;
  localparam int CfgIdxW = 3;
  localparam int Taps    = 9;
  localparam int ProdW   = PixW + 1 + CoefW;   // zero-extended pixel times signed coefficient
  localparam int SumW    = ProdW + 4;          // room for nine products

  localparam logic [SizeW-1:0] ColsReset = 11'd640;
  localparam logic [SizeW-1:0] RowsReset = 11'd480;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_IMAGE_COLS = 3'd0,
    CFG_IMAGE_ROWS = 3'd1,
    CFG_MASK_TOP   = 3'd2,
    CFG_MASK_MID   = 3'd3,
    CFG_MASK_BOT   = 3'd4
  } cfg_idx_e;

  // Input transaction
  typedef struct packed {
    logic [PixW-1:0] pixel;
  } pix_t;

  // Output transaction
  typedef struct packed {
    logic [7:0]        filtered_value;
    logic [CoordW-1:0] center_row;
    logic [CoordW-1:0] center_col;
    logic              frame_last;
  } res_t;

  // Three mask rows, left coefficient in the low byte
  typedef struct packed {
    logic [MaskW-1:0] bot;
    logic [MaskW-1:0] mid;
    logic [MaskW-1:0] top;
  } mask_t;

  // Full 3x3 window, tap index = row * 3 + column
  typedef struct packed {
    logic [Taps-1:0][PixW-1:0] pix;
    logic [CoordW-1:0]         row;
    logic [CoordW-1:0]         col;
    logic                      last;
  } win_t;

  // Nine signed products of one window
  typedef struct packed {
    logic [Taps-1:0][ProdW-1:0] prod;
    logic [CoordW-1:0]          row;
    logic [CoordW-1:0]          col;
    logic                       last;
  } prod_t;

endpackage

// ===== hdl/c3af_stream_if.sv =====
// ----------------------------------------------------------------------------
// c3af_stream_if: valid/ready stream channel
// Carries one payload per transaction; the payload type is set per instance.
// ----------------------------------------------------------------------------
interface c3af_stream_if #(
  parameter type payload_t = logic [7:0]
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// ===== hdl/c3af_ram.sv =====
// ----------------------------------------------------------------------------
// c3af_ram: generic simple dual-port RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module c3af_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and registered read; read data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/c3af_front.sv =====
// ----------------------------------------------------------------------------
// c3af_front: raster position, line stores and 3x3 window
// Registers each pixel with its position, reads the two line stores, forms
// the window and retires the pixel into the line stores and window columns.
// ----------------------------------------------------------------------------
module c3af_front #(
  parameter int MaxCols = 1024,
  parameter int MaxRows = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [c3af_pkg::SizeW-1:0] image_cols_i,
  input  logic [c3af_pkg::SizeW-1:0] image_rows_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [c3af_pkg::PixW-1:0] in_pixel_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output c3af_pkg::win_t           out_win_o
);

  import c3af_pkg::*;

  localparam int PosW  = $clog2(MaxCols);
  localparam int RowW  = $clog2(MaxRows);
  localparam int LimA  = ($clog2(MaxCols + 1) > SizeW) ? $clog2(MaxCols + 1) : SizeW;
  localparam int LimW  = ($clog2(MaxRows + 1) > LimA) ? $clog2(MaxRows + 1) : LimA;
  localparam logic [LimW-1:0] MinSize = LimW'(3);
  localparam logic [LimW-1:0] ColsMax = LimW'(MaxCols);
  localparam logic [LimW-1:0] RowsMax = LimW'(MaxRows);
  localparam logic [LimW-1:0] One     = LimW'(1);
  localparam logic [LimW-1:0] Two     = LimW'(2);

  logic [LimW-1:0] cols_raw, rows_raw, cols, rows;
  logic [LimW-1:0] col_ext, row_ext;
  logic            acc, s1_adv, hit, last;

  logic [PosW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;

  logic            s1_valid_q;
  logic            s1_res_q;
  logic            s1_last_q;
  logic [PixW-1:0] s1_pix_q;
  logic [PosW-1:0] s1_col_q;
  logic [RowW-1:0] s1_row_q;

  logic [5:0][PixW-1:0] win_q;
  logic [2:0][PixW-1:0] col_new;
  logic [PixW-1:0]      top_rd, mid_rd;
  logic [RowW-1:0]      row_m1;
  logic [PosW-1:0]      col_m1;

  // Clamp frame size to the supported range
  always_comb begin
    cols_raw = LimW'(image_cols_i);
    rows_raw = LimW'(image_rows_i);
    if (cols_raw < MinSize) begin
      cols = MinSize;
    end else if (cols_raw > ColsMax) begin
      cols = ColsMax;
    end else begin
      cols = cols_raw;
    end
    if (rows_raw < MinSize) begin
      rows = MinSize;
    end else if (rows_raw > RowsMax) begin
      rows = RowsMax;
    end else begin
      rows = rows_raw;
    end
  end

  // Handshake: a pixel without result retires without waiting downstream
  assign s1_adv      = s1_valid_q && (!s1_res_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_adv;
  assign acc         = in_valid_i && in_ready_o;
  assign out_valid_o = s1_valid_q && s1_res_q;

  // Interior test and frame end for the current position
  always_comb begin
    col_ext = LimW'(col_q);
    row_ext = LimW'(row_q);
    hit  = (row_ext >= Two) && (col_ext >= Two) && (row_ext < rows) && (col_ext < cols);
    last = (row_ext == rows - One) && (col_ext == cols - One);
  end

  // Advance raster position
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (col_ext + One >= cols) begin
      col_d = '0;
      row_d = (row_ext + One >= rows) ? '0 : row_q + RowW'(1);
    end else begin
      col_d = col_q + PosW'(1);
    end
  end

  // Hold position, stage valid and window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      win_q      <= '0;
    end else begin
      if (acc) begin
        col_q      <= col_d;
        row_q      <= row_d;
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        win_q[0] <= win_q[3];
        win_q[1] <= win_q[4];
        win_q[2] <= win_q[5];
        win_q[3] <= top_rd;
        win_q[4] <= mid_rd;
        win_q[5] <= s1_pix_q;
      end
    end
  end

  // Capture pixel and position of the accepted transaction
  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_pix_q  <= in_pixel_i;
      s1_col_q  <= col_q;
      s1_row_q  <= row_q;
      s1_res_q  <= hit;
      s1_last_q <= last;
    end
  end

  // Line stores: read at accept, write back when the pixel retires
  c3af_ram #(.Width(PixW), .Depth(MaxCols)) u_older (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (mid_rd),
    .re_i    (acc),
    .raddr_i (col_q),
    .rdata_o (top_rd)
  );

  c3af_ram #(.Width(PixW), .Depth(MaxCols)) u_newer (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (s1_pix_q),
    .re_i    (acc),
    .raddr_i (col_q),
    .rdata_o (mid_rd)
  );

  // Assemble window: held columns plus the column the new pixel completes
  assign col_new = {s1_pix_q, mid_rd, top_rd};
  assign row_m1  = s1_row_q - RowW'(1);
  assign col_m1  = s1_col_q - PosW'(1);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      out_win_o.pix[i*3]     = win_q[i];
      out_win_o.pix[i*3 + 1] = win_q[3 + i];
      out_win_o.pix[i*3 + 2] = col_new[i];
    end
    out_win_o.row  = CoordW'(row_m1);
    out_win_o.col  = CoordW'(col_m1);
    out_win_o.last = s1_last_q;
  end

endmodule

// ===== hdl/c3af_mult.sv =====
// ----------------------------------------------------------------------------
// c3af_mult: product stage
// Multiplies the nine window pixels by their signed mask coefficients and
// registers the products.
// ----------------------------------------------------------------------------
module c3af_mult (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  c3af_pkg::mask_t mask_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  c3af_pkg::win_t  in_win_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output c3af_pkg::prod_t out_prod_o
);

  import c3af_pkg::*;

  logic [2:0][MaskW-1:0] mask_rows;
  prod_t                 prod_d, prod_q;
  logic                  valid_q, en;

  assign mask_rows = {mask_i.bot, mask_i.mid, mask_i.top};

  // Nine parallel multiplies, one per tap
  for (genvar k = 0; k < Taps; k++) begin : g_tap
    logic signed [CoefW-1:0] coef;
    assign coef = $signed(mask_rows[k / 3][CoefW*(k % 3) +: CoefW]);
    assign prod_d.prod[k] = $signed({1'b0, in_win_i.pix[k]}) * coef;
  end

  assign prod_d.row  = in_win_i.row;
  assign prod_d.col  = in_win_i.col;
  assign prod_d.last = in_win_i.last;

  // Advance when the stage is empty or drains
  assign en         = !valid_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      prod_q <= prod_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_prod_o  = prod_q;

endmodule

// ===== hdl/c3af_sum.sv =====
// ----------------------------------------------------------------------------
// c3af_sum: sum and magnitude stage
// Adds the nine products, takes the magnitude, keeps its low byte and
// holds the result transaction in the output register.
// ----------------------------------------------------------------------------
module c3af_sum (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  c3af_pkg::prod_t in_prod_i,
  c3af_stream_if.source   res_o
);

  import c3af_pkg::*;

  logic signed [SumW-1:0] sum, mag;
  res_t                   res_d, res_q;
  logic                   valid_q, en;

  // Sum of products and its magnitude
  always_comb begin
    sum = '0;
    for (int k = 0; k < Taps; k++) begin
      sum = sum + SumW'($signed(in_prod_i.prod[k]));
    end
    mag = sum[SumW-1] ? -sum : sum;
    res_d.filtered_value = mag[7:0];
    res_d.center_row     = in_prod_i.row;
    res_d.center_col     = in_prod_i.col;
    res_d.frame_last     = in_prod_i.last;
  end

  // Output register; take a new transaction when empty or drained
  assign en         = !valid_q || res_o.ready;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid   = valid_q;
  assign res_o.payload = res_q;

endmodule

// ===== hdl/conv3x3_abs_filter_unit.sv =====
// ----------------------------------------------------------------------------
// conv3x3_abs_filter_unit: streaming 3x3 convolution with magnitude output
// Raster-order 8-bit pixels in; one filtered value per interior center out.
//
//   channel   dir  transaction
//   pix_i     in   one pixel (pixel)
//   res_o     out  filtered_value, center_row, center_col, frame_last
//   cfg_*     in   register write: cfg_we_i, cfg_idx_i, cfg_data_i
//
// One pixel per clock unless the output stalls; a result passes the window stage,
// product stage and output register after the pixel that completes its window.
// The window register stage with its two line-store RAM reads sets the pace.
// Reset clears position, window and valid flags; line stores are not cleared.
// A stalled output holds the pipeline back to pix_i; pixels without a result
// retire from the window stage once it is free.
// ----------------------------------------------------------------------------
module conv3x3_abs_filter_unit #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [c3af_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [c3af_pkg::MaskW-1:0]   cfg_data_i,
  c3af_stream_if.sink                  pix_i,
  c3af_stream_if.source                res_o
);

  import c3af_pkg::*;

  logic [SizeW-1:0] cols_q, rows_q;
  mask_t            mask_q;

  logic  win_valid, win_ready;
  win_t  win;
  logic  prod_valid, prod_ready;
  prod_t prod;
  pix_t  pix_in;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= ColsReset;
      rows_q <= RowsReset;
      mask_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_IMAGE_COLS: cols_q     <= cfg_data_i[SizeW-1:0];
        CFG_IMAGE_ROWS: rows_q     <= cfg_data_i[SizeW-1:0];
        CFG_MASK_TOP:   mask_q.top <= cfg_data_i;
        CFG_MASK_MID:   mask_q.mid <= cfg_data_i;
        CFG_MASK_BOT:   mask_q.bot <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign pix_in = pix_i.payload;

  c3af_front #(.MaxCols(MAX_COLS), .MaxRows(MAX_ROWS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .image_cols_i (cols_q),
    .image_rows_i (rows_q),
    .in_valid_i   (pix_i.valid),
    .in_ready_o   (pix_i.ready),
    .in_pixel_i   (pix_in.pixel),
    .out_valid_o  (win_valid),
    .out_ready_i  (win_ready),
    .out_win_o    (win)
  );

  c3af_mult u_mult (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mask_i      (mask_q),
    .in_valid_i  (win_valid),
    .in_ready_o  (win_ready),
    .in_win_i    (win),
    .out_valid_o (prod_valid),
    .out_ready_i (prod_ready),
    .out_prod_o  (prod)
  );

  c3af_sum u_sum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (prod_valid),
    .in_ready_o (prod_ready),
    .in_prod_i  (prod),
    .res_o      (res_o)
  );

endmodule
